/* rtl/dsec_pkg.sv */
// Shared types, widths and codes of the dual-source event correlator.
`default_nettype none

package dsec_pkg;

    localparam int RING_DEPTH = 16;
    localparam int IDX_W      = $clog2(RING_DEPTH);

    localparam int CMD_W   = 2;
    localparam int ID_W    = 32;
    localparam int TIME_W  = 63;
    localparam int KIND_W  = 3;
    localparam int REG_W   = 40;
    localparam int CFG_IDX_W = 2;

    // Input commands.
    localparam logic [CMD_W-1:0] CMD_CREATE_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SWEEP    = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_MATCHED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STORED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ALERT_A = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ALERT_B = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_AGE    = 2'd1;

    localparam logic [REG_W-1:0] MATCH_WINDOW_RST = 40'd50000000;
    localparam logic [REG_W-1:0] STALE_AGE_RST    = 40'd100000000;

    // Ring selects.
    localparam logic RING_A = 1'b0;
    localparam logic RING_B = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   proc_id;
        logic [TIME_W-1:0] event_time;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   alert_id;
        logic              last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              clr_idx;
        logic              inc_idx;
        logic              ring_sel;
        logic              mark_match;
        logic              invalidate;
        logic              store_own;
        logic              emit;
        logic [KIND_W-1:0] emit_kind;
        logic              emit_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] item_cmd;
        logic             hit;
        logic             stale;
        logic             idx_last;
    } t_dp_status;

endpackage

`default_nettype wire

/* rtl/dsec_datapath.sv */
// Datapath: configuration registers, both record rings, entry compare and result register.
`default_nettype none

module dsec_datapath import dsec_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_in_item             i_in,
    input  wire logic                 i_cfg_wr,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [REG_W-1:0]     i_cfg_data,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_status                o_status,
    output logic                      o_result_strobe,
    output t_out_item                 o_result
);

    logic [REG_W-1:0]      r_match_window;
    logic [REG_W-1:0]      r_stale_age;
    t_in_item              r_item;
    logic [IDX_W-1:0]      r_idx;
    logic [ID_W-1:0]       r_ids   [2][RING_DEPTH];
    logic [TIME_W-1:0]     r_times [2][RING_DEPTH];
    logic [RING_DEPTH-1:0] r_valid   [2];
    logic [RING_DEPTH-1:0] r_matched [2];
    logic [IDX_W-1:0]      r_head    [2];
    logic                  r_out_strobe;
    t_out_item             r_out;

    logic                  own;
    logic [ID_W-1:0]       rd_id;
    logic [TIME_W-1:0]     rd_time;
    logic                  rd_live;
    logic [TIME_W:0]       sub_fwd;
    logic [TIME_W:0]       sub_rev;
    logic                  borrow;
    logic [TIME_W-1:0]     abs_diff;
    logic [IDX_W-1:0]      n_head;
    t_out_item             n_out;

    assign own     = ~i_cmd.ring_sel;
    assign rd_id   = r_ids[i_cmd.ring_sel][r_idx];
    assign rd_time = r_times[i_cmd.ring_sel][r_idx];
    assign rd_live = r_valid[i_cmd.ring_sel][r_idx] & ~r_matched[i_cmd.ring_sel][r_idx];

    // Exact 63-bit difference in both directions; the sign bit picks the magnitude.
    assign sub_fwd  = {1'b0, r_item.event_time} - {1'b0, rd_time};
    assign sub_rev  = {1'b0, rd_time} - {1'b0, r_item.event_time};
    assign borrow   = sub_fwd[TIME_W];
    assign abs_diff = borrow ? sub_rev[TIME_W-1:0] : sub_fwd[TIME_W-1:0];

    assign o_status.item_cmd = r_item.cmd;
    assign o_status.hit      = rd_live && (rd_id == r_item.proc_id)
                               && (abs_diff <= TIME_W'(r_match_window));
    assign o_status.stale    = rd_live && !borrow
                               && (sub_fwd[TIME_W-1:0] > TIME_W'(r_stale_age));
    assign o_status.idx_last = (r_idx == IDX_W'(RING_DEPTH - 1));

    assign n_head = (r_head[own] == IDX_W'(RING_DEPTH - 1)) ? '0 : r_head[own] + 1'b1;

    always_comb begin
        n_out.kind = i_cmd.emit_kind;
        n_out.last = i_cmd.emit_last;
        case (i_cmd.emit_kind)
            KIND_MATCHED, KIND_STORED: n_out.alert_id = r_item.proc_id;
            KIND_ALERT_A, KIND_ALERT_B: n_out.alert_id = rd_id;
            default: n_out.alert_id = '0;
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_window <= MATCH_WINDOW_RST;
            r_stale_age    <= STALE_AGE_RST;
            r_idx          <= '0;
            r_valid[0]     <= '0;
            r_valid[1]     <= '0;
            r_matched[0]   <= '0;
            r_matched[1]   <= '0;
            r_head[0]      <= '0;
            r_head[1]      <= '0;
            r_out_strobe   <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    REG_MATCH_WINDOW: r_match_window <= i_cfg_data;
                    REG_STALE_AGE:    r_stale_age    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr_idx) begin
                r_idx <= '0;
            end else if (i_cmd.inc_idx) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.mark_match) begin
                r_matched[i_cmd.ring_sel][r_idx] <= 1'b1;
            end
            if (i_cmd.invalidate) begin
                r_valid[i_cmd.ring_sel][r_idx] <= 1'b0;
            end
            if (i_cmd.store_own) begin
                r_valid[own][r_head[own]]   <= 1'b1;
                r_matched[own][r_head[own]] <= 1'b0;
                r_head[own]                 <= n_head;
            end
            r_out_strobe <= i_cmd.emit;
        end
    end

    // Payload storage.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
        if (i_cmd.store_own) begin
            r_ids[own][r_head[own]]   <= r_item.proc_id;
            r_times[own][r_head[own]] <= r_item.event_time;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_result_strobe = r_out_strobe;
    assign o_result        = r_out;

endmodule

`default_nettype wire

/* rtl/dsec_ctrl.sv */
// Controller: sequences ring scans for create and sweep commands.
`default_nettype none

module dsec_ctrl import dsec_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [CMD_W-1:0] i_in_cmd,
    input  wire t_dp_status       i_status,
    output logic                  o_busy,
    output t_dp_cmd               o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MATCH   = 3'd1;
    localparam logic [2:0] S_SWEEP_A = 3'd2;
    localparam logic [2:0] S_SWEEP_B = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.clr_idx = 1'b1;
                    case (i_in_cmd)
                        CMD_CREATE_A, CMD_CREATE_B: n_state = S_MATCH;
                        CMD_SWEEP: n_state = S_SWEEP_A;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MATCH: begin
                // A create from one source searches the other source's ring.
                o_cmd.ring_sel  = (i_status.item_cmd == CMD_CREATE_A) ? RING_B : RING_A;
                o_cmd.emit_last = 1'b1;
                if (i_status.hit) begin
                    o_cmd.mark_match = 1'b1;
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_kind  = KIND_MATCHED;
                    n_state          = S_IDLE;
                end else if (i_status.idx_last) begin
                    o_cmd.store_own = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = KIND_STORED;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_SWEEP_A, S_SWEEP_B: begin
                o_cmd.ring_sel  = (r_state == S_SWEEP_A) ? RING_A : RING_B;
                o_cmd.emit_kind = (r_state == S_SWEEP_A) ? KIND_ALERT_A : KIND_ALERT_B;
                if (i_status.stale) begin
                    o_cmd.invalidate = 1'b1;
                    o_cmd.emit       = 1'b1;
                end
                if (i_status.idx_last) begin
                    o_cmd.clr_idx = 1'b1;
                    n_state = (r_state == S_SWEEP_A) ? S_SWEEP_B : S_DONE;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_kind = KIND_DONE;
                o_cmd.emit_last = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* rtl/dual_source_event_correlator_top.sv */
// Top level of the dual-source event correlator.
//
// Usage: present an item on i_in and raise start; the item is transferred at
// a rising edge where start is high and busy is low. Commands are create for
// source A, create for source B, and sweep. A create scans the other source's
// ring one entry per cycle, from index 0 upward, and stops at the first entry
// that is valid, unmatched, carries the same identifier and lies within the
// match window. A miss stores the event at its own ring's head. The single
// result appears in the cycle after the deciding scan cycle. A sweep walks
// ring A and then ring B, one entry per cycle, and then reports done, with
// each stale alert transferred in the cycle after its entry is visited. The
// scan of one entry per cycle through the shared compare logic sets the
// rate. An unused command is accepted and causes nothing.
// Results are single-cycle strobes on o_result_strobe with o_result; the
// receiver cannot stall them. The configuration channel is always ready and
// must only be written while the block is idle. Synchronous reset clears both
// rings, the ring heads and the registers to their default values.
`default_nettype none

module dual_source_event_correlator_top import dsec_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_in_item             i_in,
    output logic                      o_result_strobe,
    output t_out_item                 o_result,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [REG_W-1:0]     i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       ctrl_busy;

    // Register writes never stall, so the channel is always ready.
    assign o_cfg_ready = 1'b1;
    assign busy        = ctrl_busy;

    dsec_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_in_cmd (i_in.cmd),
        .i_status (dp_status),
        .o_busy   (ctrl_busy),
        .o_cmd    (dp_cmd)
    );

    dsec_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_cfg_wr        (i_cfg_valid & o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

endmodule

`default_nettype wire

/* test/dsec_tb_pkg.sv */
// Scoreboard for the dual-source event correlator: ring predictor and result checker.
`timescale 1ns / 1ps

package dsec_tb_pkg;

    import dsec_pkg::*;

    class correlation_scoreboard;

        // Predicted contents of the two rings, indexed by RING_A / RING_B.
        bit [ID_W-1:0]   rec_pid    [2][RING_DEPTH];
        bit [TIME_W-1:0] rec_stamp  [2][RING_DEPTH];
        bit              rec_live   [2][RING_DEPTH];
        bit              rec_paired [2][RING_DEPTH];
        int unsigned     rec_head   [2];

        bit [REG_W-1:0]  window;
        bit [REG_W-1:0]  max_age;

        t_out_item       pending_reports[$];
        int unsigned     mismatches;

        function new();
            window     = MATCH_WINDOW_RST;
            max_age    = STALE_AGE_RST;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
            case (idx)
                REG_MATCH_WINDOW: window  = value;
                REG_STALE_AGE:    max_age = value;
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return pending_reports.size();
        endfunction

        function void push_report(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id, logic last);
            t_out_item rep;
            rep.kind     = kind;
            rep.alert_id = id;
            rep.last     = last;
            pending_reports.push_back(rep);
        endfunction

        // Lowest-index live, unpaired entry with the same id inside the window.
        function bit find_partner(int r, bit [ID_W-1:0] id, bit [TIME_W-1:0] t);
            bit [TIME_W-1:0] diff;
            for (int i = 0; i < RING_DEPTH; i++) begin
                if (!rec_live[r][i] || rec_paired[r][i] || rec_pid[r][i] != id)
                    continue;
                diff = (t >= rec_stamp[r][i]) ? t - rec_stamp[r][i] : rec_stamp[r][i] - t;
                if (diff <= window) begin
                    rec_paired[r][i] = 1'b1;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void log_record(int r, bit [ID_W-1:0] id, bit [TIME_W-1:0] t);
            int unsigned h;
            h = rec_head[r] % RING_DEPTH;
            rec_pid[r][h]    = id;
            rec_stamp[r][h]  = t;
            rec_live[r][h]   = 1'b1;
            rec_paired[r][h] = 1'b0;
            rec_head[r]      = (h + 1) % RING_DEPTH;
        endfunction

        function void age_out(int r, bit [TIME_W-1:0] now, logic [KIND_W-1:0] kind);
            for (int i = 0; i < RING_DEPTH; i++) begin
                if (!rec_live[r][i] || rec_paired[r][i])
                    continue;
                if (now > rec_stamp[r][i] && (now - rec_stamp[r][i]) > max_age) begin
                    push_report(kind, rec_pid[r][i], 1'b0);
                    rec_live[r][i] = 1'b0;
                end
            end
        endfunction

        // Called for every input transfer; queues the results it must cause.
        function void note_item(t_in_item item);
            int own;
            int other;
            own   = (item.cmd == CMD_CREATE_A) ? RING_A : RING_B;
            other = (item.cmd == CMD_CREATE_A) ? RING_B : RING_A;
            case (item.cmd)
                CMD_CREATE_A, CMD_CREATE_B: begin
                    if (find_partner(other, item.proc_id, item.event_time)) begin
                        push_report(KIND_MATCHED, item.proc_id, 1'b1);
                    end else begin
                        log_record(own, item.proc_id, item.event_time);
                        push_report(KIND_STORED, item.proc_id, 1'b1);
                    end
                end
                CMD_SWEEP: begin
                    age_out(RING_A, item.event_time, KIND_ALERT_A);
                    age_out(RING_B, item.event_time, KIND_ALERT_B);
                    push_report(KIND_DONE, '0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 50)
                $display("%0t: MISMATCH %0s", $time, what);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d id %h",
                                          got.kind, got.alert_id));
                return;
            end
            want = pending_reports.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.alert_id !== want.alert_id)
                report_mismatch($sformatf("alert_id %h, expected %h",
                                          got.alert_id, want.alert_id));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
        endtask

    endclass

endpackage

/* test/tb_top.sv */
// Top-level testbench of the dual-source event correlator.
`timescale 1ns / 1ps

module tb_top;

    import dsec_pkg::*;
    import dsec_tb_pkg::*;

    // The package has no name for the fourth command code; the block must
    // accept it and do nothing.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam bit [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam bit [REG_W-1:0]  REG_MAX  = {REG_W{1'b1}};

    // Covers a full sweep plus the result register.
    localparam int DRAIN_CYCLES     = 40;
    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_PER_PHASE = 58;
    localparam int POOL_SIZE        = 6;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_in_item             i_in        = '0;
    logic                 o_result_strobe;
    t_out_item            o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [REG_W-1:0]     i_cfg_data  = '0;

    correlation_scoreboard sb;

    // Random stimulus state: a drifting time base and a small pool of
    // process ids, so that creates from the two sources actually pair up.
    bit [TIME_W-1:0] time_base;
    bit [ID_W-1:0]   id_pool [POOL_SIZE];
    bit              quiet_run;
    int              stall_cycles = 0;

    dual_source_event_correlator_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_in            (i_in),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Results are strobes that cannot be stalled, so every strobed cycle is
    // a transfer and is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe)
            sb.check_result(o_result);
    end

    // The watchdog counts cycles without any transfer on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly back to back or short gaps, now and then a long one. During a
    // quiet run the driver keeps start high so items follow each other.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_run || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one item at the falling edge and hold it until busy is low at
    // a rising edge; that edge is the transfer. Returns at a falling edge
    // without touching start, so the next call may keep it high.
    task automatic put_event(input t_in_item item, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_in  <= item;
        do @(posedge i_clk); while (busy);
        sb.note_item(item);
        @(negedge i_clk);
    endtask

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                        input logic [TIME_W-1:0] t);
        t_in_item item;
        item.cmd        = cmd;
        item.proc_id    = id;
        item.event_time = t;
        put_event(item, pick_gap());
    endtask

    // Leaves valid high; the caller lowers it after the last write so that
    // valid never gets two assignments in the same step.
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, value);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [REG_W-1:0] win, input logic [REG_W-1:0] age);
        set_register(REG_MATCH_WINDOW, win);
        set_register(REG_STALE_AGE, age);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for every expected result, then let the block finish any item
    // that produces nothing (the unused command) before touching registers.
    task automatic settle();
        start <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One random item. Creates land within about two match windows of the
    // time base and sweeps within about two stale ages, so that both the
    // window and the stale boundary are hit from either side.
    function automatic t_in_item random_item();
        t_in_item    item;
        int unsigned pick;
        bit [63:0]   span;
        bit [63:0]   off;
        pick = $urandom_range(0, 99);
        item.cmd        = CMD_CREATE_A;
        item.proc_id    = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        item.event_time = time_base;
        if (pick < 80) begin
            item.cmd = $urandom_range(0, 1) ? CMD_CREATE_B : CMD_CREATE_A;
            span = {24'd0, sb.window} * 2 + 3;
            off  = rand64() % span;
            item.event_time = time_base + off[TIME_W-1:0];
        end else if (pick < 92) begin
            item.cmd = CMD_SWEEP;
            span = {24'd0, sb.max_age} * 2 + 3;
            off  = rand64() % span;
            item.event_time = time_base + off[TIME_W-1:0];
            item.proc_id    = $urandom;
        end else if (pick < 97) begin
            item.cmd        = CMD_W'($urandom_range(0, 2));
            item.proc_id    = $urandom;
            item.event_time = TIME_W'(rand64());
        end else begin
            item.cmd        = CMD_UNUSED;
            item.proc_id    = $urandom;
            item.event_time = TIME_W'(rand64());
        end
        // Let time move on, occasionally jump to a new epoch, and rotate
        // one id out of the pool now and then.
        if ($urandom_range(0, 9) == 0) begin
            span = {24'd0, sb.window} + {24'd0, sb.max_age} + 2;
            off  = rand64() % span;
            time_base = time_base + off[TIME_W-1:0];
        end
        if ($urandom_range(0, 32) == 0)
            time_base = TIME_W'(rand64());
        if ($urandom_range(0, 19) == 0)
            id_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
        return item;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            put_event(random_item(), pick_gap());
            if ($urandom_range(0, 29) == 0)
                quiet_run = ~quiet_run;
        end
    endtask

    // Runs at the reset settings: window 50000000, stale age 100000000.
    task automatic run_directed();
        logic [TIME_W-1:0] w;
        logic [TIME_W-1:0] s;
        w = TIME_W'(MATCH_WINDOW_RST);
        s = TIME_W'(STALE_AGE_RST);
        send(CMD_CREATE_A, '0, '0);
        send(CMD_CREATE_B, '0, '0);
        send(CMD_CREATE_B, '1, TIME_MAX);
        // Difference equal to the window still matches.
        send(CMD_CREATE_A, '1, TIME_MAX - w);
        send(CMD_CREATE_A, 32'h5, 63'd1000);
        // One tick beyond the window misses and is stored.
        send(CMD_CREATE_B, 32'h5, 63'd1001 + w);
        // Two candidates in ring B: the lower index pairs first, and a third
        // create finds nothing left and is stored.
        send(CMD_CREATE_B, 32'h7, 63'd2000);
        send(CMD_CREATE_B, 32'h7, 63'd2001);
        send(CMD_CREATE_A, 32'h7, 63'd2001);
        send(CMD_CREATE_A, 32'h7, 63'd2000);
        send(CMD_CREATE_A, 32'h7, 63'd2000);
        send(CMD_UNUSED, 32'hA5A5_5A5A, TIME_MAX);
        // Sweep before every timestamp: nothing is stale.
        send(CMD_SWEEP, '1, '0);
        // Age exactly equal to the stale age is not stale; one more tick is.
        send(CMD_SWEEP, '0, 63'd1000 + s);
        send(CMD_SWEEP, '0, 63'd1001 + s);
        send(CMD_CREATE_B, 32'h5555_AAAA, 63'h2AAA_AAAA_AAAA_AAAA);
        send(CMD_CREATE_A, 32'hAAAA_5555, 63'h5555_5555_5555_5555);
        send(CMD_SWEEP, '0, TIME_MAX);
    endtask

    // Wrap both rings past their depth with unmatched entries and then
    // sweep at the end of time, which should yield the longest burst.
    task automatic fill_rings();
        for (int k = 0; k < RING_DEPTH + 2; k++)
            send(CMD_CREATE_A, $urandom, {31'd0, $urandom});
        for (int k = 0; k < RING_DEPTH + 2; k++)
            send(CMD_CREATE_B, $urandom, {31'd0, $urandom});
        send(CMD_SWEEP, $urandom, TIME_MAX);
    endtask

    initial begin
        logic [REG_W-1:0] win_set;
        logic [REG_W-1:0] age_set;
        sb = new();
        quiet_run = 1'b0;
        foreach (id_pool[k])
            id_pool[k] = $urandom;
        time_base = TIME_W'(rand64());

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(RANDOM_PER_PHASE);

        // Each phase rewrites both registers with the block idle, covering
        // zero, the maximum, small and full-range settings.
        for (int phase = 1; phase <= 6; phase++) begin
            settle();
            case (phase)
                1: begin
                    win_set = '0;
                    age_set = '0;
                end
                2: begin
                    win_set = REG_MAX;
                    age_set = REG_MAX;
                end
                3: begin
                    win_set = REG_W'($urandom_range(1, 5000));
                    age_set = REG_W'($urandom_range(1, 20000));
                end
                4: begin
                    win_set = REG_W'(rand64());
                    age_set = REG_W'(rand64());
                end
                5: begin
                    win_set = REG_W'($urandom_range(0, 100));
                    age_set = '0;
                end
                default: begin
                    win_set = REG_W'(rand64());
                    age_set = REG_W'($urandom_range(0, 1000));
                end
            endcase
            apply_settings(win_set, age_set);
            if (phase == 1)
                fill_rings();
            run_random(RANDOM_PER_PHASE);
        end

        settle();
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* dual_source_event_correlator_top.f */
rtl/dsec_pkg.sv
rtl/dsec_datapath.sv
rtl/dsec_ctrl.sv
rtl/dual_source_event_correlator_top.sv
test/dsec_tb_pkg.sv
test/tb_top.sv
